>>> hw/rtl/rdcp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rdcp_pkg;

  // Item kinds carried on the input channel.
  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_SOLVE = 1'b1
  } kind_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_NODE_COUNT   = 3'd0,
    REG_INV_MASS     = 3'd1,
    REG_UNIFORM_REST = 3'd2,
    REG_USE_TABLE    = 3'd3,
    REG_MIN_FACTOR   = 3'd4,
    REG_COMPLIANCE   = 3'd5,
    REG_SUBSTEP      = 3'd6
  } reg_index_t;

  // Widths of the shared serial divider.
  localparam int unsigned DIV_NUM_W = 66;
  localparam int unsigned DIV_DEN_W = 40;

  // Saturation ceiling of the compliance term, 2^39 - 1.
  localparam logic [38:0] ALPHA_MAX = '1;

  // Clamp a 35-bit signed sum to the signed 32-bit range.
  function automatic logic [31:0] sat32(input logic signed [34:0] v);
    logic [31:0] r;
    if (v > 35'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -35'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Clamp a divider quotient to the compliance ceiling.
  function automatic logic [38:0] sat_alpha(input logic [DIV_NUM_W-1:0] q);
    logic [38:0] r;
    if (q > DIV_NUM_W'(ALPHA_MAX)) begin
      r = ALPHA_MAX;
    end else begin
      r = q[38:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/rope_distance_constraint_pass_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Load request: written to the node memory at the same edge at which it is taken.
// Solve request: the compliance term takes two divider runs (the ceiling is used when the
// substep is zero); every segment then takes the 32-step square root, and a corrected one
// also runs the 66-step serial divider three times; last, the nodes are emitted in order.
// A new request is taken once the last node is in the output register. Reset clears the
// sequencer, the output valid and the configuration registers; memories are not cleared.
module rope_distance_constraint_pass_top #(
  parameter int unsigned MAX_NODES = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration write channel.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  // Request channel.
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        kind,
  input  wire logic [4:0]  slot,
  input  wire logic [31:0] pos_x,
  input  wire logic [31:0] pos_y,
  input  wire logic [30:0] segment_rest,
  // Result channel.
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [4:0]       out_index,
  output logic [31:0]      out_x,
  output logic [31:0]      out_y,
  output logic             last
);

  localparam int unsigned AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned CW = $clog2(MAX_NODES + 1);
  localparam int unsigned NW = rdcp_pkg::DIV_NUM_W;
  localparam int unsigned DW = rdcp_pkg::DIV_DEN_W;

  typedef enum logic [4:0] {
    S_IDLE, S_AL1, S_AL1W, S_AL2W, S_WCALC,
    S_RDA, S_RDB, S_DIFF, S_SQX, S_SQY, S_ROOT_INIT, S_ROOT, S_LEN, S_CMP,
    S_M1, S_M2, S_MDIVW, S_NXW, S_NYW, S_MX, S_MY, S_MYD, S_WR0, S_WR1,
    S_EM_RD, S_EM_LD
  } state_t;

  // Configuration registers.
  logic [5:0]  node_total;
  logic [31:0] node_inverse_mass;
  logic [30:0] uniform_rest_length;
  logic        use_rest_table;
  logic [15:0] min_frac;
  logic [31:0] compliance;
  logic [23:0] dt_step;

  assign cfg_ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      node_total          <= 6'd2;
      node_inverse_mass   <= 32'd65536;
      uniform_rest_length <= 31'd65536;
      use_rest_table      <= 1'b0;
      min_frac            <= 16'd16384;
      compliance          <= 32'd0;
      dt_step             <= 24'd139810;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rdcp_pkg::REG_NODE_COUNT:   node_total          <= cfg_data[5:0];
        rdcp_pkg::REG_INV_MASS:     node_inverse_mass   <= cfg_data;
        rdcp_pkg::REG_UNIFORM_REST: uniform_rest_length <= cfg_data[30:0];
        rdcp_pkg::REG_USE_TABLE:    use_rest_table      <= cfg_data[0];
        rdcp_pkg::REG_MIN_FACTOR:   min_frac            <= cfg_data[15:0];
        rdcp_pkg::REG_COMPLIANCE:   compliance          <= cfg_data;
        rdcp_pkg::REG_SUBSTEP:      dt_step             <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  state_t state;

  // Node position memory {y, x} and rest length memory.
  logic [63:0] pos_mem [MAX_NODES];
  logic [30:0] rest_mem [MAX_NODES];
  logic [63:0] pos_rd;
  logic [30:0] rest_rd;
  logic [AW-1:0] raddr, waddr;
  logic          pos_we, rest_we;
  logic [63:0]   pos_wdata;

  // Working registers.
  logic [AW-1:0] seg, em;
  logic [CW-1:0] count;
  logic [38:0]   alpha;
  logic [DW-1:0] w;
  logic signed [31:0] x0, y0, x1, y1;
  logic [30:0]   rest_v;
  logic          dx_neg, dy_neg, shr;
  logic [32:0]   ax, ay, len, cmag;
  logic          cneg;
  logic [31:0]   m, nx, ny;
  logic [33:0]   mx, my;
  logic [63:0]   prod;
  logic [64:0]   acc;
  logic [63:0]   sq_v, sq_r, sq_bit;

  // Shared serial divider.
  logic          div_start, div_busy;
  logic [NW-1:0] div_num_in, div_num, div_q;
  logic [DW-1:0] div_den_in, div_den;
  logic [DW-1:0] div_rem;
  logic [6:0]    div_cnt;
  logic [DW:0]   div_trial;

  // Shared 32 x 32 multiplier.
  logic [31:0]   mul_a, mul_b;

  logic          load_ok;
  logic [CW-1:0] count_next;
  logic [30:0]   rest_sel;
  logic signed [32:0] dx_w, dy_w;
  logic [30:0]   sx, sy;
  logic [32:0]   min_len;
  logic [63:0]   sq_sum;
  logic [64:0]   mprod;
  logic          seg_more;
  logic signed [34:0] smx, smy;

  assign in_stall = (state != S_IDLE);
  assign load_ok  = (32'(slot) < MAX_NODES);
  assign rest_sel = use_rest_table ? rest_rd : uniform_rest_length;
  assign dx_w     = $signed({pos_rd[31], pos_rd[31:0]}) - $signed({x0[31], x0});
  assign dy_w     = $signed({pos_rd[63], pos_rd[63:32]}) - $signed({y0[31], y0});
  // Halve both components when either reaches 2^31, so the squares fit.
  assign shr      = ax[32] || ax[31] || ay[32] || ay[31];
  assign sx       = shr ? ax[31:1] : ax[30:0];
  assign sy       = shr ? ay[31:1] : ay[30:0];
  assign min_len  = prod[46:14];
  assign sq_sum   = sq_v - (sq_r + sq_bit);
  assign mprod    = {1'b0, prod} + (cmag[32] ? {1'b0, node_inverse_mass, 32'd0} : 65'd0);
  assign seg_more = (32'(seg) + 32'd2 < 32'(count));
  assign smx = (dx_neg != cneg) ? -$signed({1'b0, mx}) : $signed({1'b0, mx});
  assign smy = (dy_neg != cneg) ? -$signed({1'b0, my}) : $signed({1'b0, my});

  // Clamp the node count to the supported range.
  always_comb begin
    if (node_total < 6'd2) begin
      count_next = CW'(2);
    end else if (32'(node_total) > MAX_NODES) begin
      count_next = CW'(MAX_NODES);
    end else begin
      count_next = CW'(node_total);
    end
  end

  // Multiplier operand selection by step.
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (state)
      S_SQX: begin mul_a = {1'b0, sx}; mul_b = {1'b0, sx}; end
      S_SQY: begin mul_a = {1'b0, sy}; mul_b = {1'b0, sy}; end
      S_LEN: begin mul_a = {1'b0, rest_v}; mul_b = {16'd0, min_frac}; end
      S_M1:  begin mul_a = cmag[31:0]; mul_b = node_inverse_mass; end
      S_MX:  begin mul_a = m; mul_b = nx; end
      S_MY:  begin mul_a = m; mul_b = ny; end
      default: ;
    endcase
  end

  // Divider request selection by step.
  always_comb begin
    div_start  = 1'b0;
    div_num_in = '0;
    div_den_in = '0;
    case (state)
      S_AL1: begin
        div_start  = (dt_step != 24'd0);
        div_num_in = NW'({compliance, 24'd0});
        div_den_in = DW'(dt_step);
      end
      S_AL1W: begin
        div_start  = !div_busy;
        div_num_in = NW'({rdcp_pkg::sat_alpha(div_q), 24'd0});
        div_den_in = DW'(dt_step);
      end
      S_M2: begin
        div_start  = 1'b1;
        div_num_in = NW'(mprod);
        div_den_in = w;
      end
      S_MDIVW: begin
        div_start  = !div_busy;
        div_num_in = NW'({ax, 30'd0});
        div_den_in = DW'(len);
      end
      S_NXW: begin
        div_start  = !div_busy;
        div_num_in = NW'({ay, 30'd0});
        div_den_in = DW'(len);
      end
      default: ;
    endcase
  end

  // Memory port addressing and write data.
  always_comb begin
    raddr     = seg;
    waddr     = seg;
    pos_we    = 1'b0;
    rest_we   = 1'b0;
    pos_wdata = {pos_y, pos_x};
    case (state)
      S_IDLE: begin
        waddr   = AW'(slot);
        pos_we  = in_valid && (kind == rdcp_pkg::KIND_LOAD) && load_ok;
        rest_we = pos_we;
      end
      S_RDB:   raddr = seg + AW'(1);
      S_EM_RD: raddr = em;
      S_EM_LD: raddr = em;
      S_WR0: begin
        pos_we    = 1'b1;
        pos_wdata = {rdcp_pkg::sat32(35'(y0) + smy), rdcp_pkg::sat32(35'(x0) + smx)};
      end
      S_WR1: begin
        waddr     = seg + AW'(1);
        pos_we    = 1'b1;
        pos_wdata = {rdcp_pkg::sat32(35'(y1) - smy), rdcp_pkg::sat32(35'(x1) - smx)};
      end
      default: ;
    endcase
  end

  // Node memories with registered read.
  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[waddr] <= pos_wdata;
    end
    if (rest_we) begin
      rest_mem[waddr] <= segment_rest;
    end
    pos_rd  <= pos_mem[raddr];
    rest_rd <= rest_mem[raddr];
  end

  // Restoring divider, one quotient bit per cycle.
  assign div_trial = {div_rem, div_num[NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_cnt  <= '0;
    end else if (div_start) begin
      div_busy <= 1'b1;
      div_cnt  <= 7'(NW - 1);
      div_num  <= div_num_in;
      div_den  <= div_den_in;
      div_rem  <= '0;
    end else if (div_busy) begin
      div_num <= {div_num[NW-2:0], 1'b0};
      if (div_trial >= {1'b0, div_den}) begin
        div_rem <= DW'(div_trial - {1'b0, div_den});
        div_q   <= {div_q[NW-2:0], 1'b1};
      end else begin
        div_rem <= div_trial[DW-1:0];
        div_q   <= {div_q[NW-2:0], 1'b0};
      end
      if (div_cnt == 7'd0) begin
        div_busy <= 1'b0;
      end else begin
        div_cnt <= div_cnt - 7'd1;
      end
    end
  end

  // Sequencer: compliance term, segment walk, node stream.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      seg       <= '0;
      em        <= '0;
      count     <= CW'(2);
    end else begin
      // The stream step sets the output valid itself.
      if (out_valid && !out_stall && state != S_EM_LD) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && kind == rdcp_pkg::KIND_SOLVE) begin
            count <= count_next;
            state <= S_AL1;
          end
        end
        S_AL1: begin
          if (dt_step == 24'd0) begin
            alpha <= rdcp_pkg::ALPHA_MAX;
            state <= S_WCALC;
          end else begin
            state <= S_AL1W;
          end
        end
        S_AL1W: if (!div_busy) state <= S_AL2W;
        S_AL2W: begin
          if (!div_busy) begin
            alpha <= rdcp_pkg::sat_alpha(div_q);
            state <= S_WCALC;
          end
        end
        S_WCALC: begin
          w     <= DW'({node_inverse_mass, 1'b0}) + DW'(alpha);
          seg   <= '0;
          state <= S_RDA;
        end
        S_RDA: state <= S_RDB;
        S_RDB: begin
          x0     <= pos_rd[31:0];
          y0     <= pos_rd[63:32];
          rest_v <= rest_sel;
          state  <= S_DIFF;
        end
        S_DIFF: begin
          x1     <= pos_rd[31:0];
          y1     <= pos_rd[63:32];
          dx_neg <= dx_w[32];
          dy_neg <= dy_w[32];
          ax     <= dx_w[32] ? 33'(-dx_w) : 33'(dx_w);
          ay     <= dy_w[32] ? 33'(-dy_w) : 33'(dy_w);
          state  <= S_SQX;
        end
        S_SQX: state <= S_SQY;
        S_SQY: begin
          acc   <= {1'b0, prod};
          state <= S_ROOT_INIT;
        end
        S_ROOT_INIT: begin
          sq_v   <= acc[63:0] + prod;
          sq_r   <= '0;
          sq_bit <= 64'd1 << 62;
          state  <= S_ROOT;
        end
        // Digit-by-digit square root, one result bit per cycle.
        S_ROOT: begin
          if (sq_v >= sq_r + sq_bit) begin
            sq_v <= sq_sum;
            sq_r <= (sq_r >> 1) + sq_bit;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_bit <= sq_bit >> 2;
          if (sq_bit[0]) state <= S_LEN;
        end
        S_LEN: begin
          len   <= shr ? {sq_r[31:0], 1'b0} : {1'b0, sq_r[31:0]};
          state <= S_CMP;
        end
        // Decide whether the segment is stretched, squeezed or left alone.
        S_CMP: begin
          if (len > 33'(rest_v)) begin
            cmag <= len - 33'(rest_v);
            cneg <= 1'b0;
          end else begin
            cmag <= min_len - len;
            cneg <= 1'b1;
          end
          if ((len <= 33'(rest_v) && len >= min_len) || w == '0 || len == '0) begin
            if (seg_more) begin
              seg   <= seg + AW'(1);
              state <= S_RDA;
            end else begin
              em    <= '0;
              state <= S_EM_RD;
            end
          end else begin
            state <= S_M1;
          end
        end
        S_M1: state <= S_M2;
        S_M2: state <= S_MDIVW;
        S_MDIVW: begin
          if (!div_busy) begin
            m     <= div_q[31:0];
            state <= S_NXW;
          end
        end
        S_NXW: begin
          if (!div_busy) begin
            nx    <= div_q[31:0];
            state <= S_NYW;
          end
        end
        S_NYW: begin
          if (!div_busy) begin
            ny    <= div_q[31:0];
            state <= S_MX;
          end
        end
        S_MX: state <= S_MY;
        S_MY: begin
          mx    <= prod[63:30];
          state <= S_MYD;
        end
        S_MYD: begin
          my    <= prod[63:30];
          state <= S_WR0;
        end
        S_WR0: state <= S_WR1;
        S_WR1: begin
          if (seg_more) begin
            seg   <= seg + AW'(1);
            state <= S_RDA;
          end else begin
            em    <= '0;
            state <= S_EM_RD;
          end
        end
        S_EM_RD: state <= S_EM_LD;
        // Load the output register once it is free.
        S_EM_LD: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            out_index <= 5'(em);
            out_x     <= pos_rd[31:0];
            out_y     <= pos_rd[63:32];
            last      <= (32'(em) + 32'd1 == 32'(count));
            if (32'(em) + 32'd1 == 32'(count)) begin
              state <= S_IDLE;
            end else begin
              em    <= em + AW'(1);
              state <= S_EM_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A new result appears only from the node stream step.
  a_out_from_stream: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EM_LD))
    else $error("result raised outside node stream");

  // The divider is never restarted while it is running.
  a_div_no_overlap: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // Writeback of the far node stays inside the nodes in use.
  a_wb_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR1) |-> (32'(seg) + 32'd1 < 32'(count)))
    else $error("writeback beyond node count");

  // The square root walks a single bit position.
  a_root_bit: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROOT) |-> $onehot(sq_bit))
    else $error("square root bit lost");

endmodule

`default_nettype wire
